[design/b64e_pkg.sv]
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] PAD_CHAR = 7'h3d;

   localparam logic [7:0] MASK_S0_HI = 8'hfc;
   localparam logic [7:0] MASK_S1_LO = 8'h03;
   localparam logic [7:0] MASK_S1_HI = 8'hf0;
   localparam logic [7:0] MASK_S2_LO = 8'h0f;
   localparam logic [7:0] MASK_S2_HI = 8'hc0;
   localparam logic [7:0] MASK_S3_LO = 8'h3f;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] nbytes;
      logic       msg_end;
   } group_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] s);
      logic [6:0] c;
      if (s < 6'd26) begin
         c = 7'h41 + {1'b0, s};
      end else if (s < 6'd52) begin
         c = 7'h61 + {1'b0, s} - 7'd26;
      end else if (s < 6'd62) begin
         c = 7'h30 + {1'b0, s} - 7'd52;
      end else if (s == 6'd62) begin
         c = 7'h2b;
      end else begin
         c = 7'h2f;
      end
      return c;
   endfunction

endpackage

[design/b64e_front.sv]
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                in_present,
   input  logic                in_end,
   output logic                grp_valid,
   output b64e_pkg::group_type grp
);
   import b64e_pkg::*;

   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      pend0_in  = pend0_ff;
      pend1_in  = pend1_ff;
      fill_in   = fill_ff;
      grp_valid = 1'b0;
      grp       = '0;
      grp.msg_end = in_end;
      if (in_valid) begin
         if (in_present) begin
            if (fill_ff == 2'd2) begin
               grp_valid  = 1'b1;
               grp.b0     = pend0_ff;
               grp.b1     = pend1_ff;
               grp.b2     = in_byte;
               grp.nbytes = 2'd3;
               fill_in    = 2'd0;
               pend0_in   = 8'h00;
               pend1_in   = 8'h00;
            end else begin
               if (fill_ff[0]) begin
                  pend1_in = in_byte;
               end else begin
                  pend0_in = in_byte;
               end
               fill_in = fill_ff + 2'd1;
            end
         end
         if (in_end) begin
            if (fill_in != 2'd0) begin
               grp_valid  = 1'b1;
               grp.b0     = pend0_in;
               grp.b1     = (fill_in == 2'd2) ? pend1_in : 8'h00;
               grp.b2     = 8'h00;
               grp.nbytes = fill_in;
            end
            fill_in  = 2'd0;
            pend0_in = 8'h00;
            pend1_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 2'd0;
         pend0_ff <= 8'h00;
         pend1_ff <= 8'h00;
      end else begin
         fill_ff  <= fill_in;
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
      end
   end

endmodule

[design/b64e_queue.sv]
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64e_pkg::group_type push_data,
   output logic                has_room,
   input  logic                pop,
   output logic                head_valid,
   output b64e_pkg::group_type head
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign has_room   = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && has_room;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/b64e_back.sv]
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  b64e_pkg::group_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [6:0]          out_char,
   output logic                out_run_last,
   output logic                out_msg_done
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       load;
   logic [5:0] sextet;

   assign load = head_valid && (!valid_ff || out_ready);
   assign pop  = load && (idx_ff == 2'd3);

   always_comb begin
      case (idx_ff)
         2'd0: sextet = 6'((head.b0 & MASK_S0_HI) >> 2);
         2'd1: sextet = {2'(head.b0 & MASK_S1_LO), 4'((head.b1 & MASK_S1_HI) >> 4)};
         2'd2: sextet = {4'(head.b1 & MASK_S2_LO), 2'((head.b2 & MASK_S2_HI) >> 6)};
         2'd3: sextet = 6'(head.b2 & MASK_S3_LO);
         default: sextet = 6'd0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = (idx_ff <= head.nbytes) ? sextet_char(sextet) : PAD_CHAR;
         last_in  = (idx_ff == 2'd3);
         done_in  = (idx_ff == 2'd3) && head.msg_end;
         idx_in   = idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign out_valid    = valid_ff;
   assign out_char     = char_ff;
   assign out_run_last = last_ff;
   assign out_msg_done = done_ff;

endmodule

[design/base64_stream_encoder.sv]
// Base64 encoder for a byte stream, standard alphabet with '=' padding.
// Input words arrive on the req_ channel: tdata is the message byte, tuser
// says whether the byte is present, and tlast marks the end of the message.
// Output words leave on the rsp_ channel, one ASCII character per word;
// tlast is set on the last character caused by one input word and tuser on
// the final character of the whole message.
// Every third byte, or an end of message with bytes pending, forms a group
// of four characters. A group is queued and then sent at one character per
// cycle while rsp_tready is high, so the output port sets the pace. With the
// queue and the output idle, the input word that completed its group is
// written into the queue, and its first character is then registered in the
// output register that drives rsp_.
// Input words that complete no group are taken one per cycle while the queue
// has room. When the receiver stalls, the output word holds, the queue
// fills and req_tready drops; no word is lost.
// A synchronous reset empties the queue and the output register and clears
// the pending bytes.
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] in_byte
   input  logic       req_tuser,  // [0] byte_present
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [6:0] out_char, [7] zero
   output logic       rsp_tuser,  // [0] message_done
   output logic       rsp_tlast
);
   import b64e_pkg::*;

   logic      req_fire;
   logic      grp_valid;
   group_type grp;
   logic      head_valid;
   group_type head;
   logic      pop;
   logic [6:0] out_char;

   assign req_fire = req_tvalid && req_tready;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_fire),
      .in_byte    (req_tdata),
      .in_present (req_tuser),
      .in_end     (req_tlast),
      .grp_valid  (grp_valid),
      .grp        (grp)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_valid),
      .push_data  (grp),
      .has_room   (req_tready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_char     (out_char),
      .out_run_last (rsp_tlast),
      .out_msg_done (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, out_char};

endmodule

[design/b64e_checker.sv]
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   a_reset_clears_output : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output word valid right after reset");

   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("message end flagged on a word that does not end its run");

   a_ascii_only : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7])
      else $error("output character outside seven-bit ASCII");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled output word changed");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
